// ----- sv/assert_macros.svh -----
// Assertion macros shared by the frame filter RTL.
// Clocked on aclk, disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FGOTF_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("frame filter check failed");
`define FGOTF_NEVER(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("frame filter forbidden condition");
`else
`define FGOTF_ASSERT(label, prop)
`define FGOTF_NEVER(label, expr)
`endif
`endif

// ----- sv/fgotf_pkg.sv -----
// Package for the frame gain/offset temporal filter.
// Widths, register indexes, configuration type and saturation helper.
`timescale 1ns / 1ps
`default_nettype none
package fgotf_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int PIX_W    = 24;
    localparam int SIZE_W   = 9;
    localparam int GAIN_W   = 16;
    localparam int T_W      = 17;
    localparam int AMP_W    = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SZW      = 13;

    localparam int DMAG_W   = PIX_W + 1;
    localparam int SUM_W    = DMAG_W + 1;
    localparam int TA_W     = T_W + AMP_W;
    localparam int LPROD_W  = T_W + 1 + PIX_W;
    localparam int PART_W   = TA_W / 2 + DMAG_W;
    localparam int EXT_W    = 50;
    localparam int QB       = 25;
    localparam int REM_W    = SUM_W + 1;
    localparam int Q_DEPTH  = 4;

    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_GAIN         = 3'd2,
        REG_OFFSET       = 3'd3,
        REG_TIME_CONST   = 3'd4,
        REG_AMPLITUDE    = 3'd5,
        REG_OVERWRITE    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [SIZE_W-1:0] frame_width;
        logic [SIZE_W-1:0] frame_height;
        logic [GAIN_W-1:0] gain;
        logic [PIX_W-1:0]  offset;
        logic [T_W-1:0]    time_constant;
        logic [AMP_W-1:0]  nonlinear_amplitude;
        logic              overwrite_mode;
    } cfg_t;

    function automatic int bits_min1(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    function automatic logic [PIX_W-1:0] sat_pix(input logic signed [EXT_W-1:0] v);
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        hi = EXT_W'(signed'(24'sh7fffff));
        lo = EXT_W'(signed'(24'sh800000));
        if (v > hi) return hi[PIX_W-1:0];
        if (v < lo) return lo[PIX_W-1:0];
        return v[PIX_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- sv/fgotf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module fgotf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ----- sv/fgotf_front.sv -----
// Front end: accepts pixels, tracks raster position, applies gain and offset.
// Depends on fgotf_pkg; feeds the item queue.
`timescale 1ns / 1ps
`default_nettype none
module fgotf_front import fgotf_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int AW         = bits_min1(MAX_WIDTH * MAX_HEIGHT),
    parameter int DW         = AW + 1 + PIX_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cfg_t             cfg,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [PIX_W-1:0] s_pixel_in,
    output logic                  push,
    output logic      [DW-1:0]    push_data,
    input  wire logic             q_full
);
    localparam int CW = bits_min1(MAX_WIDTH);
    localparam int RW = bits_min1(MAX_HEIGHT);
    localparam int PROD_W = GAIN_W + 1 + PIX_W;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          last_next;

    logic              f1_valid_reg;
    logic [PIX_W-1:0]  f1_px_reg;
    logic [AW-1:0]     f1_addr_reg;
    logic              f1_last_reg;

    logic              f2_valid_reg;
    logic [PROD_W-1:0] f2_prod_reg;
    logic [AW-1:0]     f2_addr_reg;
    logic              f2_last_reg;

    logic              fen;
    logic              accept;
    logic [SZW-1:0]    fw_ext, fh_ext, wcl, hcl;
    logic [AW-1:0]     addr_cur;
    logic signed [PROD_W-1:0]  prod_c;
    logic signed [PROD_W:0]    rnd_c;
    logic signed [EXT_W-1:0]   sum_c;

    assign fen     = !f2_valid_reg || !q_full;
    assign s_ready = fen;
    assign accept  = s_valid && fen;

    always_comb begin
        fw_ext = SZW'(cfg.frame_width);
        fh_ext = SZW'(cfg.frame_height);
        wcl = (fw_ext == '0) ? SZW'(1) :
              ((fw_ext > SZW'(MAX_WIDTH)) ? SZW'(MAX_WIDTH) : fw_ext);
        hcl = (fh_ext == '0) ? SZW'(1) :
              ((fh_ext > SZW'(MAX_HEIGHT)) ? SZW'(MAX_HEIGHT) : fh_ext);
        col_next  = col_reg;
        row_next  = row_reg;
        last_next = 1'b0;
        if ((SZW'(col_reg) + SZW'(1)) >= wcl) begin
            col_next = '0;
            if ((SZW'(row_reg) + SZW'(1)) >= hcl) begin
                row_next  = '0;
                last_next = 1'b1;
            end else begin
                row_next = RW'(SZW'(row_reg) + SZW'(1));
            end
        end else begin
            col_next = CW'(SZW'(col_reg) + SZW'(1));
        end
        addr_cur = AW'(32'(row_reg) * 32'(MAX_WIDTH) + 32'(col_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (fen) begin
                f1_valid_reg <= accept;
                f2_valid_reg <= f1_valid_reg;
            end
        end
    end

    assign prod_c = $signed({1'b0, cfg.gain}) * $signed(f1_px_reg);

    always_ff @(posedge aclk) begin
        if (fen) begin
            f1_px_reg   <= s_pixel_in;
            f1_addr_reg <= addr_cur;
            f1_last_reg <= last_next;
            f2_prod_reg <= prod_c;
            f2_addr_reg <= f1_addr_reg;
            f2_last_reg <= f1_last_reg;
        end
    end

    always_comb begin
        rnd_c = (PROD_W + 1)'($signed(f2_prod_reg)) + (PROD_W + 1)'(2048);
        sum_c = EXT_W'(rnd_c >>> 12) + EXT_W'($signed(cfg.offset));
    end

    assign push      = f2_valid_reg && !q_full;
    assign push_data = {f2_addr_reg, f2_last_reg, sat_pix(sum_c)};
endmodule
`default_nettype wire

// ----- sv/fgotf_queue.sv -----
// Short FIFO between front end and update pipeline.
// Depends on fgotf_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none
module fgotf_queue import fgotf_pkg::*; #(
    parameter int DW = 41
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire logic [DW-1:0] push_data,
    input  wire logic          pop,
    output logic               full,
    output logic               not_empty,
    output logic      [DW-1:0] head
);
    localparam int PW = $clog2(Q_DEPTH);

    logic [DW-1:0] slot_reg [Q_DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [PW:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == (PW + 1)'(Q_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 1'b1;
        if (!push && pop) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

// ----- sv/fgotf_back.sv -----
// Back end: frame store read, blend arithmetic, pipelined divider, write-back.
// Depends on fgotf_pkg and fgotf_ram.
`timescale 1ns / 1ps
`default_nettype none
module fgotf_back import fgotf_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int AW         = bits_min1(MAX_WIDTH * MAX_HEIGHT),
    parameter int DW         = AW + 1 + PIX_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cfg_t             cfg,
    input  wire logic             q_not_empty,
    input  wire logic [DW-1:0]    q_head,
    output logic                  q_pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic      [PIX_W-1:0] m_pixel_out,
    output logic                  m_frame_end
);
    localparam int HALF = TA_W / 2;

    typedef struct packed {
        logic [AW-1:0]    addr;
        logic             last;
        logic [PIX_W-1:0] corr;
    } item_t;

    typedef struct packed {
        item_t             it;
        logic              neg;
        logic [DMAG_W-1:0] dmag;
        logic [SUM_W-1:0]  s;
        logic [TA_W-1:0]   ta;
        logic [LPROD_W-1:0] p_old;
        logic [LPROD_W-1:0] p_cor;
    } b2_t;

    typedef struct packed {
        item_t             it;
        logic              neg;
        logic [SUM_W-1:0]  s;
        logic [PIX_W-1:0]  lin;
        logic [PART_W-1:0] pl;
        logic [PART_W-1:0] ph;
    } b3_t;

    typedef struct packed {
        item_t            it;
        logic             neg;
        logic [SUM_W-1:0] s;
        logic [PIX_W-1:0] lin;
        logic [REM_W-1:0] rem;
        logic [QB-1:0]    low;
        logic [QB-1:0]    q;
    } div_t;

    logic              en;
    logic              hazard;
    item_t             head_it;
    logic [PIX_W-1:0]  old_rd;

    logic   b1_valid_reg;
    item_t  b1_reg;
    logic   b2_valid_reg;
    b2_t    b2_reg, b2_next;
    logic   b3_valid_reg;
    b3_t    b3_reg, b3_next;
    logic   div_valid_reg [QB+1];
    div_t   div_reg       [QB+1];
    div_t   div_next      [QB+1];

    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pix_reg;
    logic             out_last_reg;
    logic [PIX_W-1:0] res_next;

    logic [T_W-1:0]   tc;
    logic [T_W-1:0]   tinv;

    assign head_it = q_head;
    assign en      = !out_valid_reg || m_ready;
    assign q_pop   = q_not_empty && en && !hazard;

    always_comb begin
        hazard = b1_valid_reg && (b1_reg.addr == head_it.addr);
        if (b2_valid_reg && (b2_reg.it.addr == head_it.addr)) hazard = 1'b1;
        if (b3_valid_reg && (b3_reg.it.addr == head_it.addr)) hazard = 1'b1;
        for (int k = 0; k <= QB; k++) begin
            if (div_valid_reg[k] && (div_reg[k].it.addr == head_it.addr)) hazard = 1'b1;
        end
    end

    fgotf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH * MAX_HEIGHT),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (en && div_valid_reg[QB]),
        .waddr (div_reg[QB].it.addr),
        .wdata (res_next),
        .re    (q_pop),
        .raddr (head_it.addr),
        .rdata (old_rd)
    );

    // delta, magnitude and first products
    always_comb begin
        logic signed [DMAG_W-1:0] delta;
        tc    = (cfg.time_constant > T_ONE) ? T_ONE : cfg.time_constant;
        tinv  = T_ONE - tc;
        delta = DMAG_W'($signed(b1_reg.corr)) - DMAG_W'($signed(old_rd));
        b2_next.it    = b1_reg;
        b2_next.neg   = delta[DMAG_W-1];
        b2_next.dmag  = delta[DMAG_W-1] ? DMAG_W'(-delta) : DMAG_W'(delta);
        b2_next.s     = SUM_W'(cfg.nonlinear_amplitude) + SUM_W'(b2_next.dmag);
        b2_next.ta    = TA_W'(tc) * TA_W'(cfg.nonlinear_amplitude);
        b2_next.p_old = LPROD_W'($signed({1'b0, tc}) * $signed(old_rd));
        b2_next.p_cor = LPROD_W'($signed({1'b0, tinv}) * $signed(b1_reg.corr));
    end

    // linear result and split products for the nonlinear numerator
    always_comb begin
        logic signed [LPROD_W:0] acc;
        acc = (LPROD_W + 1)'($signed(b2_reg.p_old)) + (LPROD_W + 1)'($signed(b2_reg.p_cor))
            + (LPROD_W + 1)'(32768);
        b3_next.it  = b2_reg.it;
        b3_next.neg = b2_reg.neg;
        b3_next.s   = b2_reg.s;
        b3_next.lin = sat_pix(EXT_W'(acc >>> 16));
        b3_next.pl  = PART_W'(b2_reg.ta[HALF-1:0]) * PART_W'(b2_reg.dmag);
        b3_next.ph  = PART_W'(b2_reg.ta[TA_W-1:HALF]) * PART_W'(b2_reg.dmag);
    end

    // numerator assembly, then one quotient bit per stage
    always_comb begin
        logic [EXT_W+16-1:0] x;
        x = ((EXT_W + 16)'(b3_reg.ph) << HALF) + (EXT_W + 16)'(b3_reg.pl)
          + ((EXT_W + 16)'(b3_reg.s) << 15);
        div_next[0].it  = b3_reg.it;
        div_next[0].neg = b3_reg.neg;
        div_next[0].s   = b3_reg.s;
        div_next[0].lin = b3_reg.lin;
        div_next[0].rem = REM_W'(x[EXT_W+15:16+QB]);
        div_next[0].low = x[16+QB-1:16];
        div_next[0].q   = '0;
    end

    for (genvar k = 1; k <= QB; k++) begin : g_div
        always_comb begin
            logic [REM_W-1:0] trial;
            logic             ge;
            trial = {div_reg[k-1].rem[REM_W-2:0], div_reg[k-1].low[QB-1]};
            ge    = trial >= REM_W'(div_reg[k-1].s);
            div_next[k]     = div_reg[k-1];
            div_next[k].rem = ge ? trial - REM_W'(div_reg[k-1].s) : trial;
            div_next[k].low = {div_reg[k-1].low[QB-2:0], 1'b0};
            div_next[k].q   = {div_reg[k-1].q[QB-2:0], ge};
        end
    end

    always_comb begin
        logic signed [EXT_W-1:0] ce;
        logic signed [EXT_W-1:0] nl;
        ce = EXT_W'($signed(div_reg[QB].it.corr));
        nl = div_reg[QB].neg ? ce + $signed(EXT_W'(div_reg[QB].q))
                             : ce - $signed(EXT_W'(div_reg[QB].q));
        if (cfg.overwrite_mode) begin
            res_next = div_reg[QB].it.corr;
        end else if (cfg.nonlinear_amplitude == '0) begin
            res_next = div_reg[QB].lin;
        end else begin
            res_next = sat_pix(nl);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= QB; k++) div_valid_reg[k] <= 1'b0;
        end else if (en) begin
            b1_valid_reg     <= q_pop;
            b2_valid_reg     <= b1_valid_reg;
            b3_valid_reg     <= b2_valid_reg;
            div_valid_reg[0] <= b3_valid_reg;
            for (int k = 1; k <= QB; k++) div_valid_reg[k] <= div_valid_reg[k-1];
            out_valid_reg    <= div_valid_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_reg       <= head_it;
            b2_reg       <= b2_next;
            b3_reg       <= b3_next;
            for (int k = 0; k <= QB; k++) div_reg[k] <= div_next[k];
            out_pix_reg  <= res_next;
            out_last_reg <= div_reg[QB].it.last;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_pixel_out = out_pix_reg;
    assign m_frame_end = out_last_reg;
endmodule
`default_nettype wire

// ----- sv/frame_gain_offset_temporal_filter.sv -----
// Frame gain/offset temporal filter. Takes one pixel per clock in raster
// order, unless stalled by a full queue, output back-pressure or a store
// hazard, and returns one result per pixel in the same order.
// Each update is a read-modify-write of the pixel's store entry through a
// 29-stage update pipeline (store read, two arithmetic stages, numerator setup
// and a 25-stage one-bit-per-stage divider), so a pixel whose entry is still in
// that pipeline waits until the entry has been written back. Pixels of other
// entries can enter while earlier ones are still in the pipeline.
// Store entries hold nothing defined until their first write; there is no
// clearing pass after reset. Configuration writes take effect at once and
// belong to idle periods.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module frame_gain_offset_temporal_filter import fgotf_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [PIX_W-1:0]      s_pixel_in,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [PIX_W-1:0]      m_pixel_out,
    output logic                       m_frame_end
);
    localparam int AW = bits_min1(MAX_WIDTH * MAX_HEIGHT);
    localparam int DW = AW + 1 + PIX_W;

    cfg_t          cfg_reg;
    logic          q_push, q_pop, q_full, q_not_empty;
    logic [DW-1:0] q_in, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width         <= SIZE_W'(256);
            cfg_reg.frame_height        <= SIZE_W'(256);
            cfg_reg.gain                <= GAIN_W'(4096);
            cfg_reg.offset              <= '0;
            cfg_reg.time_constant       <= '0;
            cfg_reg.nonlinear_amplitude <= '0;
            cfg_reg.overwrite_mode      <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  cfg_reg.frame_width         <= cfg_data[SIZE_W-1:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height        <= cfg_data[SIZE_W-1:0];
                REG_GAIN:         cfg_reg.gain                <= cfg_data[GAIN_W-1:0];
                REG_OFFSET:       cfg_reg.offset              <= cfg_data[PIX_W-1:0];
                REG_TIME_CONST:   cfg_reg.time_constant       <= cfg_data[T_W-1:0];
                REG_AMPLITUDE:    cfg_reg.nonlinear_amplitude <= cfg_data[AMP_W-1:0];
                REG_OVERWRITE:    cfg_reg.overwrite_mode      <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    fgotf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW),
        .DW         (DW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel_in (s_pixel_in),
        .push       (q_push),
        .push_data  (q_in),
        .q_full     (q_full)
    );

    fgotf_queue #(
        .DW (DW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    fgotf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW),
        .DW         (DW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out),
        .m_frame_end (m_frame_end)
    );

    `FGOTF_NEVER(a_no_overflow, q_push && q_full)
    `FGOTF_NEVER(a_no_underflow, q_pop && !q_not_empty)
    `FGOTF_ASSERT(a_stall_only_full, !s_ready |-> q_full)
    `FGOTF_ASSERT(a_pop_needs_room, q_pop |-> (!m_valid || m_ready))
endmodule
`default_nettype wire
